### rtl/sbpe_pkg.sv
`timescale 1ns / 1ps

package sbpe_pkg;

    localparam int IDX_W = 12;
    localparam int N_W   = 5;
    localparam int SQ_W  = 10;
    localparam int SEC_W = 2;

    localparam logic [SEC_W-1:0] LAST_SECTION = 2'd2;

    // decoded stabilizer position handed from the divider to the path emitter
    typedef struct packed {
        logic             err;
        logic [SEC_W-1:0] sec;
        logic [N_W-1:0]   row;
        logic [N_W-1:0]   col;
        logic [IDX_W-1:0] base;
    } t_dec;

endpackage

### rtl/stabilizer_boundary_path_emitter.sv
`timescale 1ns / 1ps

// Stabilizer boundary path emitter. Each input item is one flagged stabilizer
// index of a three-section lattice with half width N (register half_size,
// reset 2, written through i_cfg_we / i_cfg_data; the user must write it only
// while the block is idle, the block itself does not enforce this). The block
// answers with the data-qubit indices that the correction toggles, one result
// item per qubit (1..N per path), o_last on the final one; an index of
// 3*N*(N+1) or more, or N of zero, gives a single item with o_out_of_range set.
// The index is split into section, row and col by repeated subtraction on one
// shared subtractor, one step a cycle: accept, one subtraction of N*(N+1) per
// section passed, one of N per row passed, then hold until the emitter takes it.
// The emitter passes a setup state, skipped for an out-of-range item, then gives
// one result item per cycle while i_ready is high, overlapping the next decode.
module stabilizer_boundary_path_emitter
    import sbpe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: half_size
    input  logic             i_cfg_we,
    input  logic [N_W-1:0]   i_cfg_data,
    // input items
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [IDX_W-1:0] i_stabilizer_index,
    // result items
    output logic             o_valid,
    input  logic             i_ready,
    output logic [IDX_W-1:0] o_qubit_index,
    output logic             o_toggle_phase,
    output logic             o_out_of_range,
    output logic             o_last
);

    // half size and the section size N*(N+1), kept ready at write time
    logic [N_W-1:0]  r_n;
    logic [SQ_W-1:0] r_sq;
    logic [SQ_W-1:0] n_sq;
    logic [N_W:0]    cfg_np1;

    assign cfg_np1 = {1'b0, i_cfg_data} + (N_W+1)'(1);
    assign n_sq    = {{(SQ_W-N_W-1){1'b0}}, cfg_np1} * {{(SQ_W-N_W){1'b0}}, i_cfg_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n  <= N_W'(2);
            r_sq <= SQ_W'(6);
        end else if (i_cfg_we) begin
            r_n  <= i_cfg_data;
            r_sq <= n_sq;
        end
    end

    // hand-off between the divider and the emitter
    t_dec dec;
    logic dec_valid;
    logic take;

    // section / row / col split by iterative subtraction
    sbpe_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n         (r_n),
        .i_sq        (r_sq),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_idx       (i_stabilizer_index),
        .o_dec_valid (dec_valid),
        .i_take      (take),
        .o_dec       (dec)
    );

    // path walk, one qubit per cycle while i_ready is high, out of a registered output
    sbpe_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_n            (r_n),
        .i_dec_valid    (dec_valid),
        .o_take         (take),
        .i_dec          (dec),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_qubit_index  (o_qubit_index),
        .o_toggle_phase (o_toggle_phase),
        .o_out_of_range (o_out_of_range),
        .o_last         (o_last)
    );

endmodule

### rtl/sbpe_decode.sv
`timescale 1ns / 1ps

module sbpe_decode
    import sbpe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [N_W-1:0]   i_n,
    input  logic [SQ_W-1:0]  i_sq,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [IDX_W-1:0] i_idx,
    output logic             o_dec_valid,
    input  logic             i_take,
    output t_dec             o_dec
);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_SEC  = 4'b0010,
        D_ROW  = 4'b0100,
        D_DONE = 4'b1000
    } t_dstate;

    t_dstate          r_state, n_state;
    logic [IDX_W-1:0] r_rem, n_rem;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic [N_W-1:0]   r_row, n_row;
    logic [IDX_W-1:0] r_base, n_base;
    logic             r_err, n_err;

    // shared subtract and compare unit
    logic [IDX_W-1:0] operand;
    logic [IDX_W:0]   diff;
    logic             borrow;

    assign operand = (r_state == D_SEC) ? {{(IDX_W-SQ_W){1'b0}}, i_sq}
                                        : {{(IDX_W-N_W){1'b0}}, i_n};
    assign diff    = {1'b0, r_rem} - {1'b0, operand};
    assign borrow  = diff[IDX_W];

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_sec   = r_sec;
        n_row   = r_row;
        n_base  = r_base;
        n_err   = r_err;
        unique case (r_state)
            D_IDLE: begin
                if (i_valid) begin
                    n_rem   = i_idx;
                    n_sec   = '0;
                    n_row   = '0;
                    n_base  = IDX_W'(1);
                    n_err   = (i_n == '0);
                    n_state = (i_n == '0) ? D_DONE : D_SEC;
                end
            end
            D_SEC: begin
                if (!borrow) begin
                    if (r_sec == LAST_SECTION) begin
                        n_err   = 1'b1;
                        n_state = D_DONE;
                    end else begin
                        n_rem  = diff[IDX_W-1:0];
                        n_sec  = r_sec + SEC_W'(1);
                        n_base = r_base + {{(IDX_W-SQ_W){1'b0}}, i_sq};
                    end
                end else begin
                    n_state = D_ROW;
                end
            end
            D_ROW: begin
                if (!borrow) begin
                    n_rem = diff[IDX_W-1:0];
                    n_row = r_row + N_W'(1);
                end else begin
                    n_state = D_DONE;
                end
            end
            D_DONE: begin
                if (i_take) begin
                    n_state = D_IDLE;
                end
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem  <= n_rem;
        r_sec  <= n_sec;
        r_row  <= n_row;
        r_base <= n_base;
        r_err  <= n_err;
    end

    assign o_ready     = (r_state == D_IDLE);
    assign o_dec_valid = (r_state == D_DONE);
    assign o_dec.err   = r_err;
    assign o_dec.sec   = r_sec;
    assign o_dec.row   = r_row;
    assign o_dec.col   = r_rem[N_W-1:0];
    assign o_dec.base  = r_base;

endmodule

### rtl/sbpe_emit.sv
`timescale 1ns / 1ps

module sbpe_emit
    import sbpe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [N_W-1:0]   i_n,
    input  logic             i_dec_valid,
    output logic             o_take,
    input  t_dec             i_dec,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [IDX_W-1:0] o_qubit_index,
    output logic             o_toggle_phase,
    output logic             o_out_of_range,
    output logic             o_last
);

    typedef enum logic [2:0] {
        E_IDLE  = 3'b001,
        E_SETUP = 3'b010,
        E_EMIT  = 3'b100
    } t_estate;

    t_estate          r_state, n_state;
    logic [N_W-1:0]   r_mul_a, n_mul_a;
    logic [N_W-1:0]   r_add_b, n_add_b;
    logic [N_W:0]     r_step, n_step;
    logic [N_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0] r_base, n_base;
    logic [IDX_W-1:0] r_q, n_q;
    logic             r_phase, n_phase;
    logic             r_err, n_err;

    logic [N_W:0]     np1;
    logic             par;
    logic             edge_row;
    logic             along;
    logic [N_W-1:0]   start, fixed, cnt0;
    logic [10:0]      prod;

    assign np1      = {1'b0, i_n} + (N_W+1)'(1);
    assign par      = i_dec.row[0] ^ i_dec.col[0];
    assign edge_row = (i_dec.row == i_n);
    assign prod     = {5'b0, np1} * {6'b0, r_mul_a};

    // path shape from the stabilizer position
    always_comb begin
        if (edge_row) begin
            along = ~(i_n[0] ^ i_dec.col[0]);
            if (along) begin
                start = i_dec.col;
                fixed = i_n;
            end else begin
                start = i_dec.col + N_W'(1);
                fixed = i_n - N_W'(1);
            end
            cnt0 = i_n - i_dec.col;
        end else begin
            along = ~par;
            if (along) begin
                start = i_dec.row;
                fixed = i_dec.col + N_W'(1);
                cnt0  = i_n - i_dec.row;
            end else begin
                start = i_dec.col + N_W'(1);
                fixed = i_dec.row;
                cnt0  = i_n - i_dec.col;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_mul_a = r_mul_a;
        n_add_b = r_add_b;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_base  = r_base;
        n_q     = r_q;
        n_phase = r_phase;
        n_err   = r_err;
        unique case (r_state)
            E_IDLE: begin
                if (i_dec_valid) begin
                    if (i_dec.err) begin
                        n_q     = '0;
                        n_phase = 1'b0;
                        n_err   = 1'b1;
                        n_cnt   = N_W'(1);
                        n_state = E_EMIT;
                    end else begin
                        n_mul_a = along ? start : fixed;
                        n_add_b = along ? fixed : start;
                        n_step  = along ? np1 : (N_W+1)'(1);
                        n_cnt   = cnt0;
                        n_base  = i_dec.base;
                        n_phase = (i_dec.sec == LAST_SECTION) ? par : ~par;
                        n_err   = 1'b0;
                        n_state = E_SETUP;
                    end
                end
            end
            E_SETUP: begin
                n_q     = r_base + {1'b0, prod} + {{(IDX_W-N_W){1'b0}}, r_add_b};
                n_state = E_EMIT;
            end
            E_EMIT: begin
                if (i_ready) begin
                    if (r_cnt == N_W'(1)) begin
                        n_state = E_IDLE;
                    end else begin
                        n_q   = r_q + {{(IDX_W-N_W-1){1'b0}}, r_step};
                        n_cnt = r_cnt - N_W'(1);
                    end
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mul_a <= n_mul_a;
        r_add_b <= n_add_b;
        r_step  <= n_step;
        r_cnt   <= n_cnt;
        r_base  <= n_base;
        r_q     <= n_q;
        r_phase <= n_phase;
        r_err   <= n_err;
    end

    assign o_take         = (r_state == E_IDLE) && i_dec_valid;
    assign o_valid        = (r_state == E_EMIT);
    assign o_qubit_index  = r_q;
    assign o_toggle_phase = r_phase;
    assign o_out_of_range = r_err;
    assign o_last         = (r_cnt == N_W'(1));

endmodule

### rtl/sbpe_checker.sv
`timescale 1ns / 1ps

module sbpe_checker
    import sbpe_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic [IDX_W-1:0] o_qubit_index,
    input logic             o_toggle_phase,
    input logic             o_out_of_range,
    input logic             o_last
);

    // an error item stands alone
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_last)
        else $error("out of range item without last");

    // an error item carries a zero index and bit-flip kind
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> (o_qubit_index == '0) && !o_toggle_phase)
        else $error("out of range item with payload");

    // data qubit indices start at one
    a_qubit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_of_range |-> (o_qubit_index != '0))
        else $error("valid path item with qubit index zero");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_qubit_index) && $stable(o_last))
        else $error("stalled result item changed");

endmodule

bind stabilizer_boundary_path_emitter sbpe_checker u_sbpe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_qubit_index  (o_qubit_index),
    .o_toggle_phase (o_toggle_phase),
    .o_out_of_range (o_out_of_range),
    .o_last         (o_last)
);

### test/tb_stabilizer_boundary_path_emitter.sv
`timescale 1ns / 1ps

module tb_stabilizer_boundary_path_emitter;
    import sbpe_pkg::*;

    // lattice half width saturates here
    localparam int MAX_HALF_SIZE = 31;
    localparam int RAND_ITEMS    = 195;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 60;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int DIR_ROWS      = 25;

    // one toggle as the block reports it
    typedef struct packed {
        logic [IDX_W-1:0] qubit;
        logic             phase;
        logic             oor;
        logic             last;
    } t_qubit_toggle;

    // one row of the directed stimulus
    typedef struct packed {
        bit               set_n;
        logic [N_W-1:0]   n;
        logic [IDX_W-1:0] idx;
        bit               typed;
        t_qubit_toggle    res;
    } t_stim_row;

    localparam t_qubit_toggle NO_RES  = '0;
    localparam t_qubit_toggle OOR_RES = '{12'd0, 1'b0, 1'b1, 1'b1};

    // directed part: reset value first, then each path shape on a small lattice,
    // the half size 1 lattice, the widest lattice, the empty lattice and half size 3
    localparam t_stim_row DIR_TBL [0:DIR_ROWS-1] = '{
        // reset half size of 2: inner even, inner odd, past the lattice
        '{1'b0, 5'd0,  12'd0,    1'b0, NO_RES},
        '{1'b0, 5'd0,  12'd1,    1'b0, NO_RES},
        '{1'b0, 5'd0,  12'd18,   1'b1, OOR_RES},
        '{1'b0, 5'd0,  12'd4095, 1'b1, OOR_RES},
        // half size 2: edge row both parities, middle and last section
        '{1'b1, 5'd2,  12'd4,    1'b0, NO_RES},
        '{1'b0, 5'd2,  12'd5,    1'b0, NO_RES},
        '{1'b0, 5'd2,  12'd9,    1'b0, NO_RES},
        '{1'b0, 5'd2,  12'd12,   1'b0, NO_RES},
        '{1'b0, 5'd2,  12'd16,   1'b0, NO_RES},
        '{1'b0, 5'd2,  12'd17,   1'b0, NO_RES},
        // half size 1: every path is a single qubit
        '{1'b1, 5'd1,  12'd0,    1'b1, '{12'd2, 1'b1, 1'b0, 1'b1}},
        '{1'b0, 5'd1,  12'd1,    1'b1, '{12'd2, 1'b0, 1'b0, 1'b1}},
        '{1'b0, 5'd1,  12'd5,    1'b1, '{12'd6, 1'b1, 1'b0, 1'b1}},
        '{1'b0, 5'd1,  12'd6,    1'b1, OOR_RES},
        // widest lattice: full-length paths and the last cell
        '{1'b1, 5'd31, 12'd0,    1'b0, NO_RES},
        '{1'b0, 5'd31, 12'd30,   1'b0, NO_RES},
        '{1'b0, 5'd31, 12'd961,  1'b0, NO_RES},
        '{1'b0, 5'd31, 12'd2975, 1'b0, NO_RES},
        '{1'b0, 5'd31, 12'd2976, 1'b1, OOR_RES},
        // empty lattice: everything is out of range
        '{1'b1, 5'd0,  12'd0,    1'b1, OOR_RES},
        '{1'b0, 5'd0,  12'd4095, 1'b1, OOR_RES},
        // half size 3
        '{1'b1, 5'd3,  12'd0,    1'b0, NO_RES},
        '{1'b0, 5'd3,  12'd7,    1'b0, NO_RES},
        '{1'b0, 5'd3,  12'd35,   1'b0, NO_RES},
        '{1'b0, 5'd3,  12'd36,   1'b1, OOR_RES}
    };

    logic             i_clk              = 1'b0;
    logic             i_rst_n            = 1'b0;
    logic             i_cfg_we           = 1'b0;
    logic [N_W-1:0]   i_cfg_data         = '0;
    logic             i_valid            = 1'b0;
    logic             o_ready;
    logic [IDX_W-1:0] i_stabilizer_index = '0;
    logic             o_valid;
    logic             i_ready            = 1'b0;
    logic [IDX_W-1:0] o_qubit_index;
    logic             o_toggle_phase;
    logic             o_out_of_range;
    logic             o_last;

    // expected toggles, oldest first
    t_qubit_toggle toggle_q [$];
    // half size as the block holds it
    logic [N_W-1:0] half_size_cfg = 5'd2;

    int  fail_count    = 0;
    int  items_sent    = 0;
    int  rand_sent     = 0;
    int  results_seen  = 0;
    int  oor_seen      = 0;
    int  settings_used = 1;
    int  burst_left    = 0;
    bit  hold_request  = 1'b0;
    bit  hold_done     = 1'b0;

    stabilizer_boundary_path_emitter u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_stabilizer_index (i_stabilizer_index),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_qubit_index      (o_qubit_index),
        .o_toggle_phase     (o_toggle_phase),
        .o_out_of_range     (o_out_of_range),
        .o_last             (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // append one expected toggle at the tail of the queue
    task automatic add_toggle(input t_qubit_toggle t);
        toggle_q.insert(toggle_q.size(), t);
    endtask

    // queue the toggles that one stabilizer index should produce
    task automatic predict_path(input logic [IDX_W-1:0] idx, input logic [N_W-1:0] n_cfg);
        int unsigned   n, sq, sec, rem, row, col, base, start, stop, fixed, v;
        bit            along_rows;
        t_qubit_toggle t;
        n = n_cfg;
        if (n > MAX_HALF_SIZE)
            n = MAX_HALF_SIZE;
        sq = n * (n + 1);
        // empty lattice or index past the last section
        if (n == 0 || idx >= 3 * sq) begin
            add_toggle(OOR_RES);
            return;
        end
        sec  = idx / sq;
        rem  = idx - sec * sq;
        row  = rem / n;
        col  = rem - row * n;
        base = 1 + sec * sq;
        // last section flips the sense of the toggle kind
        t.phase = (sec < 2) ? ((row + col) % 2 == 0) : ((row + col) % 2 == 1);
        t.oor   = 1'b0;
        if (row == n) begin
            // edge row: walk down column n or along row n-1
            if ((n - col) % 2 == 0) begin
                along_rows = 1'b1; start = col;     stop = n;     fixed = n;
            end else begin
                along_rows = 1'b0; start = col + 1; stop = n + 1; fixed = n - 1;
            end
        end else begin
            if ((row + col) % 2 == 0) begin
                along_rows = 1'b1; start = row;     stop = n;     fixed = col + 1;
            end else begin
                along_rows = 1'b0; start = col + 1; stop = n + 1; fixed = row;
            end
        end
        for (v = start; v < stop && v < start + MAX_HALF_SIZE; v++) begin
            t.qubit = along_rows ? IDX_W'(base + (n + 1) * v + fixed)
                                 : IDX_W'(base + (n + 1) * fixed + v);
            t.last  = (v + 1 == stop);
            add_toggle(t);
        end
    endtask

    // present one index and hold it until the block takes it
    task automatic offer_index(input logic [IDX_W-1:0] idx, input bit typed,
                               input t_qubit_toggle res);
        i_valid            <= 1'b1;
        i_stabilizer_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (typed)
            add_toggle(res);
        else
            predict_path(idx, half_size_cfg);
    endtask

    // bursts of back-to-back items separated by short random gaps
    task automatic sender_pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 6);
        i_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
    endtask

    // change the half size only once the block has drained
    task automatic set_half_size(input logic [N_W-1:0] n);
        i_valid <= 1'b0;
        while (toggle_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        half_size_cfg = n;
        settings_used++;
    endtask

    // mostly cells inside the lattice, some anywhere in the 12-bit range,
    // now and then the first index just past the lattice
    function automatic logic [IDX_W-1:0] pick_index(input logic [N_W-1:0] n);
        int unsigned span;
        span = 3 * int'(n) * (int'(n) + 1);
        if (span == 0 || $urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, 4095));
        if ($urandom_range(0, 19) == 0)
            return IDX_W'(span);
        return IDX_W'($urandom_range(0, span - 1));
    endfunction

    // receiver: stretches of free flow and of random stalls, plus one long
    // hold-off on request so the block backs up into its input
    initial begin : receiver
        int span;
        bit free_run;
        @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            free_run = ($urandom_range(0, 2) == 0);
            span     = $urandom_range(8, 40);
            repeat (span) begin
                i_ready <= free_run ? 1'b1 : ($urandom_range(0, 3) != 0);
                @(posedge i_clk);
            end
        end
    end

    // compare every accepted result with the oldest expected toggle
    always @(posedge i_clk) begin : result_check
        t_qubit_toggle want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_out_of_range)
                oor_seen++;
            if (toggle_q.size() == 0) begin
                $error("unexpected result item: qubit_index %0d", o_qubit_index);
                fail_count++;
            end else begin
                want = toggle_q.pop_front();
                if (o_qubit_index !== want.qubit) begin
                    $error("qubit_index: expected %0d, got %0d", want.qubit, o_qubit_index);
                    fail_count++;
                end
                if (o_toggle_phase !== want.phase) begin
                    $error("toggle_phase: expected %0b, got %0b", want.phase, o_toggle_phase);
                    fail_count++;
                end
                if (o_out_of_range !== want.oor) begin
                    $error("out_of_range: expected %0b, got %0b", want.oor, o_out_of_range);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // stimulus, drain and verdict
    initial begin : stimulus
        int             row_no;
        int             phase_no;
        int             count;
        logic [N_W-1:0] n_next;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (row_no = 0; row_no < DIR_ROWS; row_no++) begin
            if (DIR_TBL[row_no].set_n)
                set_half_size(DIR_TBL[row_no].n);
            offer_index(DIR_TBL[row_no].idx, DIR_TBL[row_no].typed, DIR_TBL[row_no].res);
            sender_pace();
        end

        // random phases, each with its own half size; the widest lattice and
        // the empty one get few items, the rest run mostly on small lattices
        phase_no = 0;
        while (rand_sent < RAND_ITEMS) begin
            case (phase_no % 6)
                0: begin
                    n_next = 5'd31;
                    count  = 8;
                end
                1: begin
                    n_next = 5'd1;
                    count  = 25;
                end
                2: begin
                    n_next = 5'd0;
                    count  = 6;
                end
                default: begin
                    n_next = ($urandom_range(0, 4) == 0) ? N_W'($urandom_range(9, 30))
                                                         : N_W'($urandom_range(2, 8));
                    count  = 35;
                end
            endcase
            set_half_size(n_next);
            // long receiver hold-off while this phase keeps offering items
            if (phase_no == 3)
                hold_request = 1'b1;
            repeat (count) begin
                if (rand_sent < RAND_ITEMS) begin
                    offer_index(pick_index(half_size_cfg), 1'b0, NO_RES);
                    rand_sent++;
                    sender_pace();
                end
            end
            phase_no++;
        end

        // drain, then give the block time to show any stray result
        i_valid <= 1'b0;
        while (toggle_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d stabilizer items (%0d directed) over %0d half-size settings",
                 items_sent, DIR_ROWS, settings_used);
        $display("checked %0d result items, %0d of them out of range",
                 results_seen, oor_seen);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
